// ===== hw/rtl/ctss_pkg.sv =====
// Package for the clock time segment serializer.
// Holds the beat types, the frame constants and the segment decode function.
// It depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ctss_pkg;

    localparam int unsigned FRAME_BITS = 32;
    localparam int unsigned CNT_W      = $clog2(FRAME_BITS);

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

    // Fixed hours-tens patterns.
    localparam logic [7:0] COLON_ONLY = 8'h20;
    localparam logic [7:0] COLON_ONE  = 8'h60;

    typedef logic [FRAME_BITS-1:0] t_frame;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
    } t_time_in;

    typedef struct packed {
        logic             data_bit;
        logic [CNT_W-1:0] bit_number;
        logic             last;
    } t_bit_out;

    // Status of the frame queue as seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Seven-segment code of one decimal digit.
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'h7E;
            4'd1:    code = 8'h30;
            4'd2:    code = 8'h6D;
            4'd3:    code = 8'h79;
            4'd4:    code = 8'h33;
            4'd5:    code = 8'h5B;
            4'd6:    code = 8'h5F;
            4'd7:    code = 8'h70;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h7B;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ctss_front.sv =====
// Front stage: accepts a time beat and builds its 32-bit segment frame.
// Depends on ctss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctss_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire ctss_pkg::t_time_in i_item,
    output logic                   o_push,
    output ctss_pkg::t_frame       o_frame,
    input  wire ctss_pkg::t_q_stat i_q_stat
);

    logic             r_valid;
    ctss_pkg::t_frame r_frame;
    logic             n_valid;
    ctss_pkg::t_frame n_frame;

    logic [1:0] h_tens;
    logic [3:0] h_ones;
    logic [2:0] m_tens;
    logic [3:0] m_ones;
    logic [4:0] h_sub;
    logic [5:0] m_sub;
    logic       take;
    logic       drain;

    // Split into decimal digits by compare chains; values are narrow.
    always_comb begin
        priority if (i_item.hours >= 5'd30) h_tens = 2'd3;
        else if (i_item.hours >= 5'd20)     h_tens = 2'd2;
        else if (i_item.hours >= 5'd10)     h_tens = 2'd1;
        else                                h_tens = 2'd0;

        priority if (i_item.minutes >= 6'd60) m_tens = 3'd6;
        else if (i_item.minutes >= 6'd50)     m_tens = 3'd5;
        else if (i_item.minutes >= 6'd40)     m_tens = 3'd4;
        else if (i_item.minutes >= 6'd30)     m_tens = 3'd3;
        else if (i_item.minutes >= 6'd20)     m_tens = 3'd2;
        else if (i_item.minutes >= 6'd10)     m_tens = 3'd1;
        else                                  m_tens = 3'd0;

        h_sub  = {h_tens, 3'b000} + {2'b00, h_tens, 1'b0};
        m_sub  = {m_tens, 3'b000} + {2'b00, m_tens, 1'b0};
        h_ones = 4'(i_item.hours - h_sub);
        m_ones = 4'(i_item.minutes - m_sub);
    end

    assign drain   = r_valid && !i_q_stat.full;
    assign o_ready = !r_valid || !i_q_stat.full;
    assign take    = i_valid && o_ready;
    assign o_push  = drain;
    assign o_frame = r_frame;

    always_comb begin
        n_valid = r_valid;
        n_frame = r_frame;
        if (drain) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid = 1'b1;
            // Byte 0 goes out first, so it sits in the low bits.
            n_frame = {ctss_pkg::seg_code(m_ones),
                       ctss_pkg::seg_code({1'b0, m_tens}),
                       ctss_pkg::seg_code(h_ones),
                       (h_tens != 2'd0) ? ctss_pkg::COLON_ONE : ctss_pkg::COLON_ONLY};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_frame <= n_frame;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ctss_fifo.sv =====
// Two-entry frame queue between the front stage and the serializer.
// Depends on ctss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctss_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ctss_pkg::t_frame  i_frame,
    input  wire logic              i_pop,
    output ctss_pkg::t_frame       o_frame,
    output ctss_pkg::t_q_stat      o_stat
);

    ctss_pkg::t_frame r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             n_wr_ptr;
    logic             n_rd_ptr;
    logic [1:0]       n_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_frame      = r_mem[r_rd_ptr];

    // Drop requests that the queue cannot honor.
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ctss_back.sv =====
// Serializer: loads a frame from the queue and shifts it out one bit per beat.
// Depends on ctss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctss_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ctss_pkg::t_q_stat i_q_stat,
    input  wire ctss_pkg::t_frame  i_frame,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ctss_pkg::t_bit_out     o_item
);

    logic                       r_busy;
    ctss_pkg::t_frame           r_frame;
    logic [ctss_pkg::CNT_W-1:0] r_cnt;
    logic                       n_busy;
    ctss_pkg::t_frame           n_frame;
    logic [ctss_pkg::CNT_W-1:0] n_cnt;
    logic                       beat;
    logic                       at_last;
    logic                       free;

    assign at_last = (r_cnt == ctss_pkg::LAST_BIT);
    assign beat    = r_busy && i_ready;
    // Free to load when idle or when the last bit leaves this cycle.
    assign free    = !r_busy || (beat && at_last);
    assign o_pop   = free && !i_q_stat.empty;

    assign o_valid           = r_busy;
    assign o_item.data_bit   = r_frame[0];
    assign o_item.bit_number = r_cnt;
    assign o_item.last       = at_last;

    always_comb begin
        n_busy  = r_busy;
        n_frame = r_frame;
        n_cnt   = r_cnt;
        if (o_pop) begin
            n_busy  = 1'b1;
            n_frame = i_frame;
            n_cnt   = '0;
        end else if (free) begin
            n_busy = 1'b0;
        end else if (beat) begin
            n_frame = r_frame >> 1;
            n_cnt   = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_frame <= n_frame;
    end

`ifndef ASSERT_OFF
    a_pop_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy || (i_ready && at_last)))
        else $error("frame loaded while a frame is still shifting");

    a_bit_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat && !at_last) |=> (r_busy && r_cnt == $past(r_cnt) + 1'b1))
        else $error("bit counter did not advance after a beat");

    a_new_frame_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_busy && r_cnt == '0))
        else $error("loaded frame does not start at bit zero");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_ready) |=> (r_busy && $stable(r_cnt) && $stable(r_frame)))
        else $error("serializer moved while stalled");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/clock_time_segment_serializer.sv =====
// From an empty block, a time beat is registered in the front stage, written into
// the queue, then loaded into the serializer, whose first bit is then valid.
// Each time beat gives 32 output beats; frames follow with no gap when the sink
// takes a beat every cycle, the rate being set by the one-bit-per-cycle shift
// register in the serializer, which holds while the sink is not ready.
// Reset (i_rst_n low, synchronous) empties the front stage, queue and serializer.
`timescale 1ns / 1ps
`default_nettype none

// Top level: front stage encodes the time into a frame, a two-entry queue
// decouples it from the serializer, which shifts the frame out LSB first.
module clock_time_segment_serializer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire ctss_pkg::t_time_in i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output ctss_pkg::t_bit_out      o_item
);

    logic              push;
    logic              pop;
    ctss_pkg::t_frame  front_frame;
    ctss_pkg::t_frame  q_frame;
    ctss_pkg::t_q_stat q_stat;

    // Encode: split hours and minutes into digits, look up segment codes.
    ctss_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_push   (push),
        .o_frame  (front_frame),
        .i_q_stat (q_stat)
    );

    // Hold up to two encoded frames so the front keeps taking beats
    // while the serializer is still busy.
    ctss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (front_frame),
        .i_pop   (pop),
        .o_frame (q_frame),
        .o_stat  (q_stat)
    );

    // Shift out 32 bits per frame; last marks the store strobe bit.
    ctss_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_frame  (q_frame),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_item   (o_item)
    );

endmodule

`default_nettype wire
